// ----- rtl/core/generalized_advantage_estimator_top_assert.svh -----
// Assertion macros shared by the estimator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef GENERALIZED_ADVANTAGE_ESTIMATOR_TOP_ASSERT_SVH
`define GENERALIZED_ADVANTAGE_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication
`define GAE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GAE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/gae_pkg.sv -----
`timescale 1ns / 1ps
package gae_pkg;

	localparam int DATA_W    = 32;
	localparam int COEF_W    = 17;
	localparam int BLEN_W    = 7;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [COEF_W-1:0] ONE_Q16        = 17'd65536;
	localparam logic [COEF_W-1:0] DISCOUNT_RST   = 17'd64881;
	localparam logic [COEF_W-1:0] TRACE_DECAY_RST = 17'd62259;
	localparam logic [BLEN_W-1:0] BATCH_LEN_RST  = 7'd64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_DECAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_LEN   = 2'd2;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// one stored transition
	typedef struct packed {
		logic signed [DATA_W-1:0] reward;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] next_val;
		logic                     done;
	} entry_t;

	// stage load strobes and the advantage clear from the sequencer to the datapath
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
		logic clr_adv;
	} ctl_t;

	// value * Q1.16 coefficient back to Q16.16, round half up
	function automatic logic signed [33:0] rnd_q16(input logic signed [49:0] p);
		logic signed [49:0] s;
		s = p + 50'sd32768;
		return 34'(s >>> 16);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [35:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7fff_ffff;
		else if (v < -36'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = 32'(v);
		return r;
	endfunction

endpackage

// ----- rtl/core/gae_if.sv -----
`timescale 1ns / 1ps
interface gae_in_if;
	import gae_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] reward;
	logic signed [DATA_W-1:0] state_value;
	logic signed [DATA_W-1:0] next_value;
	logic                     episode_done;

	modport source (output valid, reward, state_value, next_value, episode_done, input ready);
	modport sink   (input valid, reward, state_value, next_value, episode_done, output ready);
endinterface

interface gae_out_if;
	import gae_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] advantage;
	logic signed [DATA_W-1:0] target_return;
	logic [IDX_W-1:0]         entry_index;
	logic                     last_of_run;

	modport source (output valid, advantage, target_return, entry_index, last_of_run,
		input ready);
	modport sink   (input valid, advantage, target_return, entry_index, last_of_run,
		output ready);
endinterface

interface gae_cfg_if;
	import gae_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gae_ram.sv -----
`timescale 1ns / 1ps
module gae_ram #(
	parameter int WIDTH = 97,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/gae_datapath.sv -----
`timescale 1ns / 1ps
module gae_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  gae_pkg::ctl_t                    ctl,
	input  gae_pkg::entry_t                  rd_entry,
	input  logic [$clog2(DEPTH)-1:0]         rd_idx,
	input  logic [gae_pkg::COEF_W-1:0]       gamma,
	input  logic [gae_pkg::COEF_W-1:0]       gamma_lambda,
	output logic signed [gae_pkg::DATA_W-1:0] advantage,
	output logic signed [gae_pkg::DATA_W-1:0] target_return,
	output logic [gae_pkg::IDX_W-1:0]        entry_index,
	output logic                             last_of_run
);
	import gae_pkg::*;

	localparam int AW = $clog2(DEPTH);

	// s1: bootstrap product, reward - value
	logic signed [49:0]       pn_s1;
	logic signed [32:0]       d0_s1;
	logic                     live_s1;
	logic signed [DATA_W-1:0] val_s1;
	logic [AW-1:0]            idx_s1;
	// s2: delta, carried-advantage product
	logic signed [34:0]       delta_s2;
	logic                     live_s2;
	logic signed [DATA_W-1:0] val_s2;
	logic [AW-1:0]            idx_s2;
	logic signed [49:0]       pc_q;
	// s3: running advantage
	logic signed [DATA_W-1:0] adv_q;
	logic signed [DATA_W-1:0] val_s3;
	logic [AW-1:0]            idx_s3;
	// output register
	logic signed [DATA_W-1:0] adv_out_q;
	logic signed [DATA_W-1:0] ret_out_q;
	logic [AW-1:0]            idx_out_q;
	logic                     last_out_q;

	logic signed [34:0] boot_term;
	logic signed [35:0] carry_term;

	assign boot_term  = live_s1 ? 35'(rnd_q16(pn_s1)) : 35'sd0;
	assign carry_term = live_s2 ? 36'(rnd_q16(pc_q)) : 36'sd0;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			pn_s1   <= $signed(rd_entry.next_val) * $signed({1'b0, gamma});
			d0_s1   <= 33'(rd_entry.reward) - 33'(rd_entry.value);
			live_s1 <= !rd_entry.done;
			val_s1  <= rd_entry.value;
			idx_s1  <= rd_idx;
		end
		if (ctl.ld_s2) begin
			delta_s2 <= 35'(d0_s1) + boot_term;
			live_s2  <= live_s1;
			val_s2   <= val_s1;
			idx_s2   <= idx_s1;
			pc_q     <= $signed(adv_q) * $signed({1'b0, gamma_lambda});
		end
		if (ctl.clr_adv) begin
			adv_q <= '0;
		end else if (ctl.ld_s3) begin
			adv_q  <= sat32(36'(delta_s2) + carry_term);
			val_s3 <= val_s2;
			idx_s3 <= idx_s2;
		end
		if (ctl.ld_out) begin
			adv_out_q  <= adv_q;
			ret_out_q  <= sat32(36'(adv_q) + 36'(val_s3));
			idx_out_q  <= idx_s3;
			last_out_q <= (idx_s3 == '0);
		end
	end

	assign advantage     = adv_out_q;
	assign target_return = ret_out_q;
	assign entry_index   = IDX_W'(idx_out_q);
	assign last_of_run   = last_out_q;

endmodule

// ----- rtl/core/generalized_advantage_estimator_top.sv -----
`timescale 1ns / 1ps
// Generalized advantage estimator.
// sample: one transition per transfer (reward, state_value, next_value,
//   episode_done), taken one per cycle while the batch store fills.
// result: one transfer per stored entry, highest index first; last_of_run
//   marks entry zero. cfg: register writes (discount, trace_decay,
//   batch_len), always ready, to be used only while the block is idle.
// The transfer that completes a batch starts the backward pass; sample is
//   held off until the pass has delivered every result.
// Path: each result passes the store read, s1, s2, s3 and the output
//   register in turn. The pass reads a new entry only on alternate
//   phases, so that the carried-advantage loop (multiply, then add and
//   saturate) of one entry is done before the next entry uses it.
// Receiver stall: the output register holds its result and the whole pass
//   pipeline freezes, including the store read, until the transfer happens.
// Reset: store contents (no clearing pass) and running advantage stay;
//   fill count and pipeline valids clear; registers take defaults.
module generalized_advantage_estimator_top #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	gae_in_if.sink   sample,
	gae_out_if.source result,
	gae_cfg_if.sink  cfg
);
	import gae_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	// configuration registers
	logic [COEF_W-1:0] disc_q;
	logic [COEF_W-1:0] decay_q;
	logic [BLEN_W-1:0] blen_q;
	logic [COEF_W-1:0] gamma_c;
	logic [COEF_W-1:0] lambda_c;
	logic [COEF_W-1:0] gl_q;
	logic [33:0]       gl_prod;
	logic [FW-1:0]     b_eff;

	// sequencer
	state_t        state_q, state_d;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rd_left_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] rd_tag_q;
	logic          ph_q;
	logic          v_rd_q, v1_q, v2_q, v3_q;
	logic          out_vld_q;

	logic   drain, en, in_xfer, full_now, last_fill, start, rd_en, pass_done;
	ctl_t   ctl;
	entry_t wr_entry, rd_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q  <= DISCOUNT_RST;
			decay_q <= TRACE_DECAY_RST;
			blen_q  <= BATCH_LEN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DISCOUNT:    disc_q  <= cfg.data[COEF_W-1:0];
				REG_TRACE_DECAY: decay_q <= cfg.data[COEF_W-1:0];
				REG_BATCH_LEN:   blen_q  <= cfg.data[BLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficients above one act as one
	assign gamma_c  = (disc_q > ONE_Q16) ? ONE_Q16 : disc_q;
	assign lambda_c = (decay_q > ONE_Q16) ? ONE_Q16 : decay_q;
	assign gl_prod  = 34'(gamma_c) * 34'(lambda_c);

	// gamma*lambda rounded to Q1.16; settles long before a pass uses it
	always_ff @(posedge clk) begin
		gl_q <= COEF_W'((gl_prod + 34'd32768) >> 16);
	end

	// batch length clamped to 1..DEPTH
	always_comb begin
		if (blen_q == '0)
			b_eff = FW'(1);
		else if (blen_q > BLEN_W'(DEPTH))
			b_eff = FW'(DEPTH);
		else
			b_eff = FW'(blen_q);
	end

	assign drain     = (state_q == ST_DRAIN);
	assign en        = !out_vld_q || result.ready;
	assign in_xfer   = sample.valid && sample.ready;
	assign full_now  = (fill_q >= b_eff);
	assign last_fill = ((fill_q + FW'(1)) == b_eff);
	// a batch shortened below the fill drops the incoming transition
	assign start     = in_xfer && (full_now || last_fill);
	assign rd_en     = drain && en && !ph_q && (rd_left_q != '0);
	assign pass_done = drain && (rd_left_q == '0) && !v_rd_q && !v1_q && !v2_q &&
		!v3_q && !out_vld_q;

	assign sample.ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (start) state_d = ST_DRAIN;
			ST_DRAIN: if (pass_done) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	// fill count and pass counters; ph_q low = read / s2 / output phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rd_left_q <= '0;
			rd_idx_q  <= '0;
			rd_tag_q  <= '0;
			ph_q      <= 1'b0;
			v_rd_q    <= 1'b0;
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (start) begin
				fill_q    <= '0;
				rd_left_q <= b_eff;
				rd_idx_q  <= AW'(b_eff - FW'(1));
				ph_q      <= 1'b0;
			end else if (in_xfer) begin
				fill_q <= fill_q + FW'(1);
			end

			if (drain && en) begin
				ph_q <= !ph_q;
				if (!ph_q) begin
					v_rd_q <= rd_en;
					v2_q   <= v1_q;
					if (rd_en) begin
						rd_left_q <= rd_left_q - FW'(1);
						rd_idx_q  <= rd_idx_q - AW'(1);
						rd_tag_q  <= rd_idx_q;
					end
				end else begin
					v1_q <= v_rd_q;
					v3_q <= v2_q;
				end
			end

			if (drain && en && !ph_q)
				out_vld_q <= v3_q;
			else if (result.ready)
				out_vld_q <= 1'b0;
		end
	end

	// the store is written only while loading and read only while draining
	assign wr_entry.reward   = sample.reward;
	assign wr_entry.value    = sample.state_value;
	assign wr_entry.next_val = sample.next_value;
	assign wr_entry.done     = sample.episode_done;

	gae_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_xfer && !full_now),
		.waddr (fill_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (rd_entry)
	);

	assign ctl.ld_s1   = drain && en && ph_q;
	assign ctl.ld_s2   = drain && en && !ph_q;
	assign ctl.ld_s3   = drain && en && ph_q && v2_q;
	assign ctl.ld_out  = drain && en && !ph_q && v3_q;
	assign ctl.clr_adv = start;

	gae_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk           (clk),
		.ctl           (ctl),
		.rd_entry      (rd_entry),
		.rd_idx        (rd_tag_q),
		.gamma         (gamma_c),
		.gamma_lambda  (gl_q),
		.advantage     (result.advantage),
		.target_return (result.target_return),
		.entry_index   (result.entry_index),
		.last_of_run   (result.last_of_run)
	);

	assign result.valid = out_vld_q;

	`include "generalized_advantage_estimator_top_assert.svh"

	`GAE_ASSERT_NOW(a_out_in_pass, result.valid, state_q == ST_DRAIN, "result outside pass")
	`GAE_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(DEPTH), "fill count beyond depth")
	`GAE_ASSERT_NXT(a_pass_continues, result.valid && result.ready && !result.last_of_run, state_q == ST_DRAIN, "pass ended before entry zero")

endmodule
